[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the box overlap engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a consequent in the same cycle as its antecedent.
`define MBOE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Check a consequent in the cycle after its antecedent.
`define MBOE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MBOE_ASSERT_SAME(label, ante, cons)
`define MBOE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/mboe_pkg.sv]
// Shared constants, types and control structs of the box overlap engine.
`default_nettype none
package mboe_pkg;

  localparam int MAX_BOXES = 64;
  localparam int NUM_TYPES = 32;

  localparam int OPC_W   = 2;
  localparam int KIND_W  = 5;
  localparam int ROW_W   = 32;
  localparam int COORD_W = 16;
  localparam int SLOT_W  = 6;
  localparam int MASK_W  = 64;

  localparam int ADDR_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W  = $clog2(MAX_BOXES + 1);

  localparam logic [ROW_W-1:0] TYPE_MASK = ROW_W'((64'd1 << NUM_TYPES) - 64'd1);

  localparam logic [OPC_W-1:0] OP_LOAD_ROW = 2'd0;
  localparam logic [OPC_W-1:0] OP_NEW_FRAME = 2'd1;
  localparam logic [OPC_W-1:0] OP_ADD_BOX = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KROW,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept_row;
    logic accept_clr;
    logic accept_box;
    logic kind_cap;
    logic scan_clr;
    logic scan_step;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } ctrl_sts_t;

endpackage
`default_nettype wire

[rtl/mboe_datapath.sv]
// Datapath: type matrix, box store, overlap pipeline, hit masks and output register.
`default_nettype none
module mboe_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire mboe_pkg::ctrl_cmd_t                   cmd,
  output mboe_pkg::ctrl_sts_t                        sts,
  input  wire logic [mboe_pkg::KIND_W-1:0]           in_row_index,
  input  wire logic [mboe_pkg::ROW_W-1:0]            in_row_bits,
  input  wire logic signed [mboe_pkg::COORD_W-1:0]   in_pos_x,
  input  wire logic signed [mboe_pkg::COORD_W-1:0]   in_pos_y,
  input  wire logic [mboe_pkg::COORD_W-1:0]          in_size_w,
  input  wire logic [mboe_pkg::COORD_W-1:0]          in_size_h,
  input  wire logic [mboe_pkg::KIND_W-1:0]           in_kind,
  input  wire logic                                  in_has_handler,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [mboe_pkg::SLOT_W-1:0]                out_slot,
  output logic [mboe_pkg::MASK_W-1:0]                out_older_notified,
  output logic [mboe_pkg::MASK_W-1:0]                out_new_notified,
  output logic                                       out_store_full
);

  localparam int AW = mboe_pkg::ADDR_W;
  localparam int CW = mboe_pkg::CNT_W;
  localparam int KW = mboe_pkg::KIND_W;
  localparam int XW = mboe_pkg::COORD_W;
  localparam int NB = mboe_pkg::MAX_BOXES;
  localparam int NT = mboe_pkg::NUM_TYPES;

  // Type matrix with one valid bit per row, box store
  logic [mboe_pkg::ROW_W-1:0] mat_mem [NT];
  logic [NT-1:0]              row_vld_r;
  logic [mboe_pkg::ROW_W-1:0] mat_q_r;
  logic [KW-1:0]              mat_addr;
  logic                       mat_in_range;
  logic                       row_ok;

  logic [4*XW-1:0] rect_mem [NB];
  logic [KW:0]     attr_mem [NB];
  logic [4*XW-1:0] rect_q_r;
  logic [KW:0]     attr_q_r;

  // New box and counters
  logic signed [XW-1:0] nx_r, ny_r;
  logic [XW-1:0]        nw_r, nh_r;
  logic [KW-1:0]        kind_r;
  logic                 hnd_r;
  logic [mboe_pkg::ROW_W-1:0] kind_row_r;
  logic [CW-1:0]        count_r;
  logic [AW-1:0]        scan_idx_r;

  // Pipeline registers
  logic          s1_vld_r, s2_vld_r;
  logic [AW-1:0] s1_idx_r, s2_idx_r;
  logic          s2_ovl_r, s2_ohnd_r;
  logic [KW-1:0] s2_okind_r;
  logic [NB-1:0] older_r, newer_r;

  // Output register
  logic              out_valid_r;
  logic [mboe_pkg::SLOT_W-1:0] out_slot_r;
  logic [mboe_pkg::MASK_W-1:0] out_older_r, out_new_r;
  logic              out_full_r;

  // Overlap of the stored box read in stage 1 against the new box
  logic signed [XW-1:0] ax, ay;
  logic [XW-1:0]        aw, ah;
  logic signed [XW+1:0] ax_e, ay_e, axw, ayh, bx_e, by_e, bxw, byh;
  logic                 ovl;

  assign ax = rect_q_r[XW-1:0];
  assign ay = rect_q_r[2*XW-1:XW];
  assign aw = rect_q_r[3*XW-1:2*XW];
  assign ah = rect_q_r[4*XW-1:3*XW];

  always_comb begin
    ax_e = (XW+2)'(ax);
    ay_e = (XW+2)'(ay);
    bx_e = (XW+2)'(nx_r);
    by_e = (XW+2)'(ny_r);
    axw  = ax_e + $signed({2'b00, aw});
    ayh  = ay_e + $signed({2'b00, ah});
    bxw  = bx_e + $signed({2'b00, nw_r});
    byh  = by_e + $signed({2'b00, nh_r});
    ovl  = (aw != '0) && (ah != '0) && (nw_r != '0) && (nh_r != '0) &&
           (ax_e < bxw) && (axw > bx_e) && (ay_e < byh) && (ayh > by_e);
  end

  // Matrix read address: kind row at accept, stored box kind during scan
  assign mat_addr     = cmd.accept_box ? in_kind : attr_q_r[KW-1:0];
  assign mat_in_range = ({1'b0, mat_addr} < (KW+1)'(NT));
  assign row_ok       = ({1'b0, in_row_index} < (KW+1)'(NT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (cmd.accept_row && row_ok) begin
      row_vld_r[in_row_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_row && row_ok) begin
      mat_mem[in_row_index] <= in_row_bits & mboe_pkg::TYPE_MASK;
    end
    mat_q_r <= (mat_in_range && row_vld_r[mat_addr]) ? mat_mem[mat_addr] : '0;
  end

  // Box store: read at the scan index, write the new box when finishing
  always_ff @(posedge clk) begin
    if (cmd.out_load && !sts.count_full) begin
      rect_mem[count_r[AW-1:0]] <= {nh_r, nw_r, ny_r, nx_r};
      attr_mem[count_r[AW-1:0]] <= {hnd_r, kind_r};
    end
    rect_q_r <= rect_mem[scan_idx_r];
    attr_q_r <= attr_mem[scan_idx_r];
  end

  // Capture the new box and its permission row
  always_ff @(posedge clk) begin
    if (cmd.accept_box) begin
      nx_r   <= in_pos_x;
      ny_r   <= in_pos_y;
      nw_r   <= in_size_w;
      nh_r   <= in_size_h;
      kind_r <= in_kind;
      hnd_r  <= in_has_handler;
    end
    if (cmd.kind_cap) begin
      kind_row_r <= mat_q_r;
    end
  end

  // Box count and scan index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      scan_idx_r <= '0;
    end else begin
      if (cmd.accept_clr) begin
        count_r <= '0;
      end else if (cmd.out_load && !sts.count_full) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.scan_clr) begin
        scan_idx_r <= '0;
      end else if (cmd.scan_step) begin
        scan_idx_r <= scan_idx_r + AW'(1);
      end
    end
  end

  // Advance the overlap pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.scan_step;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r   <= scan_idx_r;
    s2_idx_r   <= s1_idx_r;
    s2_ovl_r   <= ovl;
    s2_ohnd_r  <= attr_q_r[KW];
    s2_okind_r <= attr_q_r[KW-1:0];
  end

  // Accumulate hit masks for the current box
  always_ff @(posedge clk) begin
    if (cmd.accept_box) begin
      older_r <= '0;
      newer_r <= '0;
    end else if (s2_vld_r && s2_ovl_r) begin
      older_r[s2_idx_r] <= s2_ohnd_r && mat_q_r[kind_r];
      newer_r[s2_idx_r] <= hnd_r && kind_row_r[s2_okind_r];
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_slot_r  <= sts.count_full ? '0 : mboe_pkg::SLOT_W'(count_r[AW-1:0]);
      out_older_r <= mboe_pkg::MASK_W'(older_r);
      out_new_r   <= mboe_pkg::MASK_W'(newer_r);
      out_full_r  <= sts.count_full;
    end
  end

  // Status to the controller
  always_comb begin
    sts.count_zero = (count_r == '0);
    sts.count_full = (count_r == CW'(NB));
    sts.scan_last  = ((CW'(scan_idx_r) + CW'(1)) == count_r);
    sts.pipe_busy  = s1_vld_r || s2_vld_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_slot           = out_slot_r;
  assign out_older_notified = out_older_r;
  assign out_new_notified   = out_new_r;
  assign out_store_full     = out_full_r;

endmodule
`default_nettype wire

[rtl/mboe_ctrl.sv]
// Controller state machine: decode transactions, sequence the store scan.
`default_nettype none
module mboe_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [mboe_pkg::OPC_W-1:0] in_opcode,
  output logic                            in_ready,
  input  wire mboe_pkg::ctrl_sts_t        sts,
  output mboe_pkg::ctrl_cmd_t             cmd
);

  mboe_pkg::state_t state_r, state_nxt;
  logic             take;

  assign take = in_valid && (state_r == mboe_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mboe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mboe_pkg::ST_IDLE: begin
        if (take && in_opcode == mboe_pkg::OP_ADD_BOX) begin
          if (sts.count_full || sts.count_zero) begin
            state_nxt = mboe_pkg::ST_DONE;
          end else begin
            state_nxt = mboe_pkg::ST_KROW;
          end
        end
      end
      mboe_pkg::ST_KROW: state_nxt = mboe_pkg::ST_SCAN;
      mboe_pkg::ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = mboe_pkg::ST_DRAIN;
        end
      end
      mboe_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = mboe_pkg::ST_DONE;
        end
      end
      mboe_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = mboe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mboe_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      mboe_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.accept_row = take && (in_opcode == mboe_pkg::OP_LOAD_ROW);
        cmd.accept_clr = take && (in_opcode == mboe_pkg::OP_NEW_FRAME);
        cmd.accept_box = take && (in_opcode == mboe_pkg::OP_ADD_BOX);
      end
      mboe_pkg::ST_KROW: begin
        cmd.kind_cap = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      mboe_pkg::ST_SCAN:  cmd.scan_step = 1'b1;
      mboe_pkg::ST_DRAIN: cmd = '0;
      mboe_pkg::ST_DONE:  cmd.out_load = sts.out_free;
      default:            cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/masked_box_overlap_engine.sv]
// Top level: masked all-pairs box overlap engine with a type-pair permission matrix.
// Load-row, start-frame and unused-opcode transactions give no result; the engine stays idle.
// Add-box with n stored boxes: capture the kind row, do n store reads, then drain the
// compare pipeline (s1, s2) and load the result once any waiting result has gone; with an
// empty or full store the scan is skipped. The next item is accepted after that load.
// Reset empties the store and reads every matrix row as zero; no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module masked_box_overlap_engine (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [mboe_pkg::OPC_W-1:0]          in_opcode,
  input  wire logic [mboe_pkg::KIND_W-1:0]         in_row_index,
  input  wire logic [mboe_pkg::ROW_W-1:0]          in_row_bits,
  input  wire logic signed [mboe_pkg::COORD_W-1:0] in_pos_x,
  input  wire logic signed [mboe_pkg::COORD_W-1:0] in_pos_y,
  input  wire logic [mboe_pkg::COORD_W-1:0]        in_size_w,
  input  wire logic [mboe_pkg::COORD_W-1:0]        in_size_h,
  input  wire logic [mboe_pkg::KIND_W-1:0]         in_kind,
  input  wire logic                                in_has_handler,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [mboe_pkg::SLOT_W-1:0]              out_slot,
  output logic [mboe_pkg::MASK_W-1:0]              out_older_notified,
  output logic [mboe_pkg::MASK_W-1:0]              out_new_notified,
  output logic                                     out_store_full
);

  mboe_pkg::ctrl_cmd_t cmd;
  mboe_pkg::ctrl_sts_t sts;

  mboe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mboe_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_row_index       (in_row_index),
    .in_row_bits        (in_row_bits),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_size_w          (in_size_w),
    .in_size_h          (in_size_h),
    .in_kind            (in_kind),
    .in_has_handler     (in_has_handler),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_slot           (out_slot),
    .out_older_notified (out_older_notified),
    .out_new_notified   (out_new_notified),
    .out_store_full     (out_store_full)
  );

  // A dropped box reports slot zero and empty masks
  `MBOE_ASSERT_SAME(a_full_clean, out_valid && out_store_full,
                    out_slot == '0 && out_older_notified == '0 && out_new_notified == '0)
  // Never overwrite a result that is still waiting
  `MBOE_ASSERT_SAME(a_load_free, cmd.out_load, sts.out_free)
  // An accepted add-box transaction blocks the input until its result is loaded
  `MBOE_ASSERT_NEXT(a_add_busy,
                    in_valid && in_ready && in_opcode == mboe_pkg::OP_ADD_BOX, !in_ready)
  // The store is only scanned when it holds boxes
  `MBOE_ASSERT_SAME(a_scan_nonempty, cmd.scan_step, !sts.count_zero)

endmodule
`default_nettype wire

[verif/tb_masked_box_overlap_engine.sv]
// Self-checking testbench for the masked box overlap engine: directed and random stimulus.
module tb_masked_box_overlap_engine;

  localparam logic [mboe_pkg::OPC_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS   = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int CALM_TAIL      = 40;

  typedef struct {
    logic [mboe_pkg::OPC_W-1:0]          opcode;
    logic [mboe_pkg::KIND_W-1:0]         row_index;
    logic [mboe_pkg::ROW_W-1:0]          row_bits;
    logic signed [mboe_pkg::COORD_W-1:0] pos_x;
    logic signed [mboe_pkg::COORD_W-1:0] pos_y;
    logic [mboe_pkg::COORD_W-1:0]        size_w;
    logic [mboe_pkg::COORD_W-1:0]        size_h;
    logic [mboe_pkg::KIND_W-1:0]         kind;
    logic                                has_handler;
  } box_req_t;

  typedef struct {
    logic [mboe_pkg::SLOT_W-1:0] slot;
    logic [mboe_pkg::MASK_W-1:0] older_notified;
    logic [mboe_pkg::MASK_W-1:0] new_notified;
    logic                        store_full;
  } hit_report_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [mboe_pkg::OPC_W-1:0] in_opcode = '0;
  logic [mboe_pkg::KIND_W-1:0] in_row_index = '0;
  logic [mboe_pkg::ROW_W-1:0] in_row_bits = '0;
  logic signed [mboe_pkg::COORD_W-1:0] in_pos_x = '0;
  logic signed [mboe_pkg::COORD_W-1:0] in_pos_y = '0;
  logic [mboe_pkg::COORD_W-1:0] in_size_w = '0;
  logic [mboe_pkg::COORD_W-1:0] in_size_h = '0;
  logic [mboe_pkg::KIND_W-1:0] in_kind = '0;
  logic in_has_handler = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [mboe_pkg::SLOT_W-1:0] out_slot;
  logic [mboe_pkg::MASK_W-1:0] out_older_notified;
  logic [mboe_pkg::MASK_W-1:0] out_new_notified;
  logic out_store_full;

  masked_box_overlap_engine DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_row_index       (in_row_index),
    .in_row_bits        (in_row_bits),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_size_w          (in_size_w),
    .in_size_h          (in_size_h),
    .in_kind            (in_kind),
    .in_has_handler     (in_has_handler),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_slot           (out_slot),
    .out_older_notified (out_older_notified),
    .out_new_notified   (out_new_notified),
    .out_store_full     (out_store_full)
  );

  // Shadow copy of the permission matrix and the frame's box store
  logic [mboe_pkg::ROW_W-1:0]  perm_rows [32];
  int                          box_x [mboe_pkg::MAX_BOXES];
  int                          box_y [mboe_pkg::MAX_BOXES];
  int                          box_w [mboe_pkg::MAX_BOXES];
  int                          box_h [mboe_pkg::MAX_BOXES];
  logic [mboe_pkg::KIND_W-1:0] box_kind [mboe_pkg::MAX_BOXES];
  logic                        box_handler [mboe_pkg::MAX_BOXES];
  int                          boxes_stored;

  box_req_t    pending_reqs [$];
  hit_report_t expected_reports [$];
  box_req_t    live_req;
  hit_report_t want;

  int items_accepted = 0;
  int reports_seen = 0;
  int mismatch_count = 0;
  int adds_seen = 0;
  int full_drops = 0;
  int rows_loaded = 0;
  int frames_started = 0;
  int older_hits = 0;
  int new_hits = 0;
  int send_gap = 0;
  int take_gap = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Append one item to the stimulus queue
  function automatic void queue_req(box_req_t rq);
    pending_reqs.insert(pending_reqs.size(), rq);
  endfunction

  // Open interiors meet; an empty box meets nothing
  function automatic bit interiors_meet(int ax, int ay, int aw, int ah,
                                        int bx, int by, int bw, int bh);
    if (aw == 0 || ah == 0 || bw == 0 || bh == 0) return 1'b0;
    return (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);
  endfunction

  // Update the shadow state with one accepted transaction and queue the result of an add-box
  task automatic apply_request(input box_req_t rq);
    hit_report_t rep;
    bit          meet;
    int          i;
    case (rq.opcode)
      mboe_pkg::OP_LOAD_ROW: begin
        if (rq.row_index < mboe_pkg::NUM_TYPES)
          perm_rows[rq.row_index] = rq.row_bits & mboe_pkg::TYPE_MASK;
        rows_loaded++;
      end
      mboe_pkg::OP_NEW_FRAME: begin
        boxes_stored = 0;
        frames_started++;
      end
      mboe_pkg::OP_ADD_BOX: begin
        rep.slot = '0;
        rep.older_notified = '0;
        rep.new_notified = '0;
        rep.store_full = 1'b0;
        adds_seen++;
        if (boxes_stored >= mboe_pkg::MAX_BOXES) begin
          rep.store_full = 1'b1;
          full_drops++;
        end else begin
          for (i = 0; i < boxes_stored; i++) begin
            meet = interiors_meet(box_x[i], box_y[i], box_w[i], box_h[i],
                                  int'(rq.pos_x), int'(rq.pos_y),
                                  int'(rq.size_w), int'(rq.size_h));
            if (meet && box_handler[i] && perm_rows[box_kind[i]][rq.kind])
              rep.older_notified[i] = 1'b1;
            if (meet && rq.has_handler && perm_rows[rq.kind][box_kind[i]])
              rep.new_notified[i] = 1'b1;
          end
          box_x[boxes_stored] = int'(rq.pos_x);
          box_y[boxes_stored] = int'(rq.pos_y);
          box_w[boxes_stored] = int'(rq.size_w);
          box_h[boxes_stored] = int'(rq.size_h);
          box_kind[boxes_stored] = rq.kind;
          box_handler[boxes_stored] = rq.has_handler;
          rep.slot = mboe_pkg::SLOT_W'(boxes_stored);
          boxes_stored++;
        end
        older_hits += $countones(rep.older_notified);
        new_hits += $countones(rep.new_notified);
        expected_reports.insert(expected_reports.size(), rep);
      end
      default: ;
    endcase
  endtask

  // Random content in every field; callers override what the opcode uses
  function automatic box_req_t random_request(logic [mboe_pkg::OPC_W-1:0] op);
    box_req_t rq;
    rq.opcode = op;
    rq.row_index = mboe_pkg::KIND_W'($urandom);
    rq.row_bits = $urandom;
    rq.pos_x = mboe_pkg::COORD_W'($urandom);
    rq.pos_y = mboe_pkg::COORD_W'($urandom);
    rq.size_w = mboe_pkg::COORD_W'($urandom);
    rq.size_h = mboe_pkg::COORD_W'($urandom);
    rq.kind = mboe_pkg::KIND_W'($urandom);
    rq.has_handler = 1'($urandom);
    return rq;
  endfunction

  function automatic box_req_t row_request(int idx, logic [mboe_pkg::ROW_W-1:0] bits);
    box_req_t rq;
    rq = random_request(mboe_pkg::OP_LOAD_ROW);
    rq.row_index = mboe_pkg::KIND_W'(idx);
    rq.row_bits = bits;
    return rq;
  endfunction

  function automatic box_req_t box_request(int x, int y, int w, int h, int k, bit hnd);
    box_req_t rq;
    rq = random_request(mboe_pkg::OP_ADD_BOX);
    rq.pos_x = mboe_pkg::COORD_W'(x);
    rq.pos_y = mboe_pkg::COORD_W'(y);
    rq.size_w = mboe_pkg::COORD_W'(w);
    rq.size_h = mboe_pkg::COORD_W'(h);
    rq.kind = mboe_pkg::KIND_W'(k);
    rq.has_handler = hnd;
    return rq;
  endfunction

  // Row load with a spread of densities
  function automatic box_req_t random_row();
    logic [mboe_pkg::ROW_W-1:0] bits;
    case ($urandom_range(0, 3))
      0: bits = $urandom;
      1: bits = $urandom | $urandom;
      2: bits = '1;
      default: bits = $urandom & $urandom;
    endcase
    return row_request($urandom_range(0, 31), bits);
  endfunction

  // Boxes mostly crowd a small area so that overlaps are common
  function automatic box_req_t scattered_box();
    box_req_t rq;
    rq = random_request(mboe_pkg::OP_ADD_BOX);
    rq.has_handler = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 15) != 0) begin
      rq.pos_x = mboe_pkg::COORD_W'(int'($urandom_range(0, 160)) - 80);
      rq.pos_y = mboe_pkg::COORD_W'(int'($urandom_range(0, 160)) - 80);
      rq.size_w = mboe_pkg::COORD_W'($urandom_range(0, 48));
      rq.size_h = mboe_pkg::COORD_W'($urandom_range(0, 48));
    end
    return rq;
  endfunction

  // Idle only away from the tail, and not in every stretch of the run
  function automatic bit may_idle();
    return pending_reqs.size() >= CALM_TAIL && ((items_accepted / 60) % 3) != 2;
  endfunction

  // Driver: record accepted transactions, then hold, idle or present the next item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request(live_req);
        items_accepted++;
      end
      if (in_valid && !in_ready) begin
        // hold the payload until the transaction is taken
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (may_idle() && $urandom_range(0, 4) == 0) begin
        send_gap <= $urandom_range(0, 13);
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        live_req = pending_reqs.pop_front();
        in_opcode <= live_req.opcode;
        in_row_index <= live_req.row_index;
        in_row_bits <= live_req.row_bits;
        in_pos_x <= live_req.pos_x;
        in_pos_y <= live_req.pos_y;
        in_size_w <= live_req.size_w;
        in_size_h <= live_req.size_h;
        in_kind <= live_req.kind;
        in_has_handler <= live_req.has_handler;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [mboe_pkg::MASK_W-1:0] exp_val,
                             input logic [mboe_pkg::MASK_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      take_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual slot %0d full %0b",
                   $time, out_slot, out_store_full);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("slot", mboe_pkg::MASK_W'(want.slot), mboe_pkg::MASK_W'(out_slot));
          check_field("older_notified", want.older_notified, out_older_notified);
          check_field("new_notified", want.new_notified, out_new_notified);
          check_field("store_full", mboe_pkg::MASK_W'(want.store_full),
                      mboe_pkg::MASK_W'(out_store_full));
        end
      end
      if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        out_ready <= 1'b0;
      end else if (may_idle() && $urandom_range(0, 4) == 0) begin
        take_gap <= $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int planned;
    int frame_len;
    int frames_built;
    int i;
    for (i = 0; i < 32; i++) perm_rows[i] = '0;
    boxes_stored = 0;

    // Directed: extremes, touching edges, empty boxes, ignored opcode, empty store
    queue_req(row_request(0, 32'hFFFF_FFFF));
    queue_req(row_request(31, 32'hFFFF_FFFF));
    queue_req(row_request(7, 32'h8000_0001));
    queue_req(random_request(OP_UNUSED));
    queue_req(random_request(mboe_pkg::OP_NEW_FRAME));
    queue_req(box_request(0, 0, 10, 10, 0, 1));
    queue_req(box_request(10, 0, 5, 5, 31, 1));
    queue_req(box_request(5, 5, 10, 10, 7, 1));
    queue_req(box_request(-32768, -32768, 65535, 65535, 0, 0));
    queue_req(box_request(32767, 32767, 65535, 65535, 31, 1));
    queue_req(box_request(0, 0, 0, 10, 0, 1));
    queue_req(box_request(0, 0, 10, 0, 31, 1));
    queue_req(box_request(2, 2, 3, 3, 5, 1));
    queue_req(row_request(5, 32'hFFFF_FFFF));
    queue_req(box_request(2, 2, 3, 3, 5, 1));
    queue_req(box_request(-5, -5, 6, 6, 7, 0));
    queue_req(row_request(0, 32'h0000_0000));
    queue_req(box_request(0, 0, 20, 20, 0, 1));
    queue_req(random_request(mboe_pkg::OP_NEW_FRAME));
    queue_req(random_request(mboe_pkg::OP_NEW_FRAME));
    queue_req(box_request(0, 0, 1, 1, 31, 1));

    // Random: frames of boxes, some long enough to overflow the store
    planned = 0;
    frames_built = 0;
    while (planned < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: queue_req(random_request(OP_UNUSED));
        1, 2: begin
          queue_req(random_row());
          planned++;
        end
        default: begin
          if ($urandom_range(0, 5) != 0) begin
            queue_req(random_request(mboe_pkg::OP_NEW_FRAME));
            planned++;
          end
          frame_len = (frames_built % 7 == 1) ? $urandom_range(64, 68)
                                              : $urandom_range(1, 18);
          frames_built++;
          for (i = 0; i < frame_len; i++) begin
            if ($urandom_range(0, 11) == 0) begin
              queue_req(($urandom_range(0, 1) != 0) ? random_row()
                                                    : random_request(OP_UNUSED));
            end
            queue_req(scattered_box());
            planned++;
          end
        end
      endcase
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: sample between edges so that every update of the step has landed
    do @(negedge clk);
    while (pending_reqs.size() > 0 || in_valid || expected_reports.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d transactions: %0d box adds (%0d dropped, store full),",
             items_accepted, adds_seen, full_drops);
    $display("%0d row loads, %0d frame starts, %0d results, %0d/%0d older/new hits",
             rows_loaded, frames_started, reports_seen, older_hits, new_hits);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
